### rtl/unique_values_sorter_core_macros.svh
// Assertion macros for the unique values sorter.
// Used by modules that run concurrent checks on clk / rst_n.
`ifndef UNIQUE_VALUES_SORTER_CORE_MACROS_SVH
`define UNIQUE_VALUES_SORTER_CORE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define UVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication: when ante holds, cons holds in the next cycle.
`define UVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/uvs_pkg.sv
// Shared types and constants for the unique values sorter.
// No dependencies.
`timescale 1ns / 1ps

package uvs_pkg;

  localparam int VAL_W     = 32;
  localparam int DEPTH_DEF = 32;

  // Result of the shared compare unit.
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

### rtl/uvs_ifs.sv
// Valid/ready channel interfaces for the unique values sorter.
// Depends on uvs_pkg.
`timescale 1ns / 1ps

interface uvs_in_if;
  import uvs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic                    is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface uvs_out_if;
  import uvs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] unique_value;
  logic                    none_found;
  logic                    last_result;
  logic                    overflow;

  modport source (output valid, output unique_value, output none_found,
                  output last_result, output overflow, input ready);
  modport sink   (input valid, input unique_value, input none_found,
                  input last_result, input overflow, output ready);
endinterface

### rtl/uvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module uvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/uvs_cmp.sv
// Shared compare unit: equality and signed less-than of two words.
// Depends on uvs_pkg.
`timescale 1ns / 1ps

module uvs_cmp (
  input  logic signed [uvs_pkg::VAL_W-1:0] a,
  input  logic signed [uvs_pkg::VAL_W-1:0] b,
  output uvs_pkg::cmp_res_t                res
);
  import uvs_pkg::*;

  assign res.eq = (a == b);
  assign res.lt = (a < b);

endmodule

### rtl/unique_values_sorter_core.sv
// Top level of the unique values sorter: sequencer, element store, compare unit.
// Depends on uvs_pkg, uvs_ifs, uvs_ram, uvs_cmp and the assertion macro header.
//
//   channel | dir | beat contents
//   in_ch   | in  | value, is_last
//   out_ch  | out | unique_value, none_found, last_result, overflow
//
// While loading in_ch.ready is high; beats beyond the store depth set overflow.
// On the closing beat, the n stored elements are checked for uniqueness (zero
// never counts), then each of u results takes a full scan of the store plus its
// output beat; all work is serialized through one RAM read port. With no unique
// value the single marker beat follows the check. Reset is synchronous, active
// low; the store is not cleared. in_ch.ready is low from the closing beat until
// the final result is taken; a stalled out_ch holds its beat.
`timescale 1ns / 1ps
`include "unique_values_sorter_core_macros.svh"

module unique_values_sorter_core #(
  parameter int DEPTH = uvs_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  uvs_in_if.sink    in_ch,
  uvs_out_if.source out_ch
);
  import uvs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] ONE_C  = CW'(1);
  localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_UXRD  = 3'd1;
  localparam logic [2:0] S_UXLAT = 3'd2;
  localparam logic [2:0] S_USCAN = 3'd3;
  localparam logic [2:0] S_SSCAN = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  // control state
  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CW-1:0]    i_r, i_nxt;
  logic [CW-1:0]    j_r, j_nxt;
  logic             rv_r, rv_nxt;
  logic [AW-1:0]    ridx_r, ridx_nxt;
  logic             dup_r, dup_nxt;
  logic             found_r, found_nxt;
  logic [CW-1:0]    ucnt_r, ucnt_nxt;
  logic [CW-1:0]    emit_cnt_r, emit_cnt_nxt;
  logic [DEPTH-1:0] uniq_r, uniq_nxt;
  logic             none_r, none_nxt;
  logic             last_r, last_nxt;

  // payload
  logic signed [VAL_W-1:0] x_r, x_nxt;
  logic signed [VAL_W-1:0] cand_r, cand_nxt;
  logic [AW-1:0]           cidx_r, cidx_nxt;

  logic                    ram_we;
  logic [AW-1:0]           ram_raddr;
  logic [VAL_W-1:0]        ram_rdata;
  logic signed [VAL_W-1:0] cmp_b;
  cmp_res_t                cmp_res;
  logic                    issue;
  logic                    in_acc;
  logic                    flag;
  logic [CW-1:0]           ucnt_sum;

  uvs_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_ch.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cmp_b = (state_r == S_USCAN) ? x_r : cand_r;

  uvs_cmp u_cmp (
    .a   ($signed(ram_rdata)),
    .b   (cmp_b),
    .res (cmp_res)
  );

  assign issue     = (j_r != cnt_r);
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign ram_raddr = (state_r == S_UXRD) ? i_r[AW-1:0] : j_r[AW-1:0];
  assign flag      = !dup_r && (x_r != '0);
  assign ucnt_sum  = ucnt_r + {{(CW-1){1'b0}}, flag};

  assign in_ch.ready         = (state_r == S_LOAD);
  assign out_ch.valid        = (state_r == S_EMIT);
  assign out_ch.unique_value = cand_r;
  assign out_ch.none_found   = none_r;
  assign out_ch.last_result  = last_r;
  assign out_ch.overflow     = ovf_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    rv_nxt       = 1'b0;
    ridx_nxt     = ridx_r;
    dup_nxt      = dup_r;
    found_nxt    = found_r;
    ucnt_nxt     = ucnt_r;
    emit_cnt_nxt = emit_cnt_r;
    uniq_nxt     = uniq_r;
    none_nxt     = none_r;
    last_nxt     = last_r;
    x_nxt        = x_r;
    cand_nxt     = cand_r;
    cidx_nxt     = cidx_r;
    ram_we       = 1'b0;

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (cnt_r != FULL_C) begin
            ram_we  = 1'b1;
            cnt_nxt = cnt_r + ONE_C;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.is_last) begin
            i_nxt     = '0;
            ucnt_nxt  = '0;
            uniq_nxt  = '0;
            state_nxt = S_UXRD;
          end
        end
      end
      S_UXRD: begin
        state_nxt = S_UXLAT;
      end
      S_UXLAT: begin
        x_nxt     = $signed(ram_rdata);
        j_nxt     = '0;
        dup_nxt   = 1'b0;
        state_nxt = S_USCAN;
      end
      S_USCAN: begin
        if (issue) begin
          j_nxt    = j_r + ONE_C;
          rv_nxt   = 1'b1;
          ridx_nxt = j_r[AW-1:0];
        end
        if (rv_r && (ridx_r != i_r[AW-1:0]) && cmp_res.eq) begin
          dup_nxt = 1'b1;
        end
        if (!issue && !rv_r) begin
          uniq_nxt[i_r[AW-1:0]] = flag;
          ucnt_nxt = ucnt_sum;
          i_nxt    = i_r + ONE_C;
          if ((i_r + ONE_C) == cnt_r) begin
            emit_cnt_nxt = '0;
            if (ucnt_sum == '0) begin
              // nothing unique: single marker result
              none_nxt  = 1'b1;
              last_nxt  = 1'b1;
              cand_nxt  = '0;
              state_nxt = S_EMIT;
            end else begin
              j_nxt     = '0;
              found_nxt = 1'b0;
              state_nxt = S_SSCAN;
            end
          end else begin
            state_nxt = S_UXRD;
          end
        end
      end
      S_SSCAN: begin
        // min search over flagged entries; emitted ones get their flag cleared
        if (issue) begin
          j_nxt    = j_r + ONE_C;
          rv_nxt   = 1'b1;
          ridx_nxt = j_r[AW-1:0];
        end
        if (rv_r && uniq_r[ridx_r] && (!found_r || cmp_res.lt)) begin
          cand_nxt  = $signed(ram_rdata);
          cidx_nxt  = ridx_r;
          found_nxt = 1'b1;
        end
        if (!issue && !rv_r) begin
          none_nxt  = 1'b0;
          last_nxt  = ((emit_cnt_r + ONE_C) == ucnt_r);
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_ch.ready) begin
          emit_cnt_nxt     = emit_cnt_r + ONE_C;
          uniq_nxt[cidx_r] = 1'b0;
          if (last_r) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            j_nxt     = '0;
            found_nxt = 1'b0;
            state_nxt = S_SSCAN;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      i_r        <= '0;
      j_r        <= '0;
      rv_r       <= 1'b0;
      ridx_r     <= '0;
      dup_r      <= 1'b0;
      found_r    <= 1'b0;
      ucnt_r     <= '0;
      emit_cnt_r <= '0;
      uniq_r     <= '0;
      none_r     <= 1'b0;
      last_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      ovf_r      <= ovf_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      rv_r       <= rv_nxt;
      ridx_r     <= ridx_nxt;
      dup_r      <= dup_nxt;
      found_r    <= found_nxt;
      ucnt_r     <= ucnt_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      uniq_r     <= uniq_nxt;
      none_r     <= none_nxt;
      last_r     <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    cand_r <= cand_nxt;
    cidx_r <= cidx_nxt;
  end

  `UVS_ASSERT(a_busy_no_load, out_ch.valid |-> !in_ch.ready, "input taken while emitting")
  `UVS_ASSERT(a_cnt_range, cnt_r <= FULL_C, "element count beyond store depth")
  `UVS_ASSERT(a_none_form,
    (out_ch.valid && out_ch.none_found) |->
      (out_ch.last_result && out_ch.unique_value == '0),
    "malformed none_found beat")
  `UVS_ASSERT(a_emit_count, (state_r == S_EMIT && !none_r) |-> (emit_cnt_r < ucnt_r),
    "more results than unique values")
  `UVS_ASSERT_NEXT(a_reopen, out_ch.valid && out_ch.ready && out_ch.last_result,
    in_ch.ready && cnt_r == '0 && !ovf_r, "set not closed after final beat")

endmodule
